// File: rtl/core/md5s_pkg.sv
// MD5 stream hash package: payload structs, sequencer states, round constants
// and per-round index functions. No dependencies.
package md5s_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } md5s_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } md5s_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5s_abcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } md5s_state_t;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] g;
    begin
      lo = rnd[3:0];
      case (rnd[5:4])
        2'd0:    g = lo;
        2'd1:    g = 4'(lo * 4'd5 + 4'd1);
        2'd2:    g = 4'(lo * 4'd3 + 4'd5);
        default: g = 4'(lo * 4'd7);
      endcase
      return g;
    end
  endfunction

  // Left rotate amount used by a round.
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    return ROT_S[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage

// File: rtl/core/md5s_round.sv
// MD5 round unit: one compression round on the working words.
// Depends on md5s_pkg for the round constants and rotate amounts.
module md5s_round (
  input  md5s_pkg::md5s_abcd_t cur,
  input  logic [31:0]          w,
  input  logic [5:0]           rnd,
  output md5s_pkg::md5s_abcd_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  s;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  assign s   = md5s_pkg::rot_amount(rnd);
  assign sum = cur.a + f + md5s_pkg::ROUND_K[rnd] + w;
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rot;
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

// File: rtl/core/md5_stream_hash_core.sv
// MD5 stream hash top level: byte intake, block buffer, padding sequencer,
// 64-round compression loop and digest output. Uses md5s_pkg, md5s_round.
//
//  channel | payload            | handshake
//  msg     | cmd, data_byte     | msg_valid / msg_stall
//  dig     | digest_word, last  | dig_valid / dig_stall
//
// An append word writes its byte into the block buffer; the word that fills
// a 64-byte block adds load, 64 rounds on the shared round unit, chain add.
// A finish word runs padding at one byte per cycle (9 to 72 bytes), one or
// two compressions, then four digest words, one per accepted output cycle.
// msg_stall is high whenever the sequencer is not idle; dig holds while
// dig_stall is high. Reset (rst, synchronous) restores the initial chain.
module md5_stream_hash_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_stall,
  input  md5s_pkg::md5s_in_t  msg,
  output logic                dig_valid,
  input  logic                dig_stall,
  output md5s_pkg::md5s_out_t dig
);

  md5s_pkg::md5s_state_t state, state_next;
  md5s_pkg::md5s_abcd_t  work, round_out;

  logic [31:0] chain [4];
  logic [31:0] blk_mem [16];
  logic [31:0] rdata;
  logic [63:0] bit_length;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [1:0]  emit_idx;
  logic        finishing;
  logic        first_pad;
  logic        len_phase;

  logic        msg_take;
  logic        dig_take;
  logic        mem_we;
  logic [7:0]  wbyte;
  logic [3:0]  raddr;
  logic [7:0]  pad_val;

  assign msg_take = msg_valid && !msg_stall;
  assign dig_take = dig_valid && !dig_stall;

  always_comb begin
    if (first_pad) begin
      pad_val = md5s_pkg::PAD_BYTE;
    end else if (len_phase) begin
      pad_val = bit_length[{pos[2:0], 3'b000} +: 8];
    end else begin
      pad_val = 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      md5s_pkg::ST_IDLE: begin
        if (msg_take) begin
          if (msg.cmd == md5s_pkg::CMD_FINISH) begin
            state_next = md5s_pkg::ST_PAD;
          end else if (pos == 6'd63) begin
            state_next = md5s_pkg::ST_LOAD;
          end
        end
      end
      md5s_pkg::ST_PAD: begin
        if (pos == 6'd63) begin
          state_next = md5s_pkg::ST_LOAD;
        end
      end
      md5s_pkg::ST_LOAD: state_next = md5s_pkg::ST_ROUND;
      md5s_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = md5s_pkg::ST_ADD;
        end
      end
      md5s_pkg::ST_ADD: begin
        if (!finishing) begin
          state_next = md5s_pkg::ST_IDLE;
        end else if (len_phase) begin
          state_next = md5s_pkg::ST_EMIT;
        end else begin
          state_next = md5s_pkg::ST_PAD;
        end
      end
      md5s_pkg::ST_EMIT: begin
        if (dig_take && emit_idx == 2'd3) begin
          state_next = md5s_pkg::ST_IDLE;
        end
      end
      default: state_next = md5s_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg_stall = 1'b1;
    dig_valid = 1'b0;
    mem_we    = 1'b0;
    wbyte     = pad_val;
    raddr     = md5s_pkg::msg_index(6'd0);
    case (state)
      md5s_pkg::ST_IDLE: begin
        msg_stall = 1'b0;
        mem_we    = msg_take && (msg.cmd == md5s_pkg::CMD_APPEND);
        wbyte     = msg.data_byte;
      end
      md5s_pkg::ST_PAD: mem_we = 1'b1;
      md5s_pkg::ST_ROUND: raddr = md5s_pkg::msg_index(rnd + 6'd1);
      md5s_pkg::ST_EMIT: dig_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign dig.digest_word = chain[emit_idx];
  assign dig.word_last   = (emit_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= blk_mem[raddr];
  end

  md5s_round u_round (
    .cur (work),
    .w   (rdata),
    .rnd (rnd),
    .nxt (round_out)
  );

  always_ff @(posedge clk) begin
    case (state)
      md5s_pkg::ST_LOAD: begin
        work <= '{a: chain[0], b: chain[1], c: chain[2], d: chain[3]};
      end
      md5s_pkg::ST_ROUND: work <= round_out;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5s_pkg::ST_IDLE;
      chain[0]   <= md5s_pkg::INIT_A;
      chain[1]   <= md5s_pkg::INIT_B;
      chain[2]   <= md5s_pkg::INIT_C;
      chain[3]   <= md5s_pkg::INIT_D;
      bit_length <= '0;
      pos        <= '0;
      rnd        <= '0;
      emit_idx   <= '0;
      finishing  <= 1'b0;
      first_pad  <= 1'b0;
      len_phase  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        md5s_pkg::ST_IDLE: begin
          if (msg_take) begin
            if (msg.cmd == md5s_pkg::CMD_FINISH) begin
              finishing <= 1'b1;
              first_pad <= 1'b1;
            end else begin
              pos        <= pos + 6'd1;
              bit_length <= bit_length + 64'd8;
            end
          end
        end
        md5s_pkg::ST_PAD: begin
          pos       <= pos + 6'd1;
          first_pad <= 1'b0;
          if (!len_phase && pos == 6'd55) begin
            len_phase <= 1'b1;
          end
        end
        md5s_pkg::ST_LOAD: rnd <= '0;
        md5s_pkg::ST_ROUND: rnd <= rnd + 6'd1;
        md5s_pkg::ST_ADD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
        end
        md5s_pkg::ST_EMIT: begin
          if (dig_take) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              chain[0]   <= md5s_pkg::INIT_A;
              chain[1]   <= md5s_pkg::INIT_B;
              chain[2]   <= md5s_pkg::INIT_C;
              chain[3]   <= md5s_pkg::INIT_D;
              bit_length <= '0;
              pos        <= '0;
              finishing  <= 1'b0;
              len_phase  <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/md5s_checker.sv
// Port-level checker for md5_stream_hash_core, attached by bind.
// Depends on md5s_pkg for the payload structs.
module md5s_checker (
  input logic                clk,
  input logic                rst,
  input logic                msg_valid,
  input logic                msg_stall,
  input md5s_pkg::md5s_in_t  msg,
  input logic                dig_valid,
  input logic                dig_stall,
  input md5s_pkg::md5s_out_t dig
);

  a_no_intake_while_emit: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("input taken while digest is pending");

  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(dig))
    else $error("stalled digest word changed");

  a_digest_continues: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !dig.word_last |=> dig_valid)
    else $error("digest ended before last word");

  a_digest_ends: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && dig.word_last |=> !dig_valid)
    else $error("digest word after last word");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && msg.cmd == md5s_pkg::CMD_FINISH |=> msg_stall)
    else $error("input not held off after finish");

endmodule

bind md5_stream_hash_core md5s_checker u_md5s_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_stall (msg_stall),
  .msg       (msg),
  .dig_valid (dig_valid),
  .dig_stall (dig_stall),
  .dig       (dig)
);
